/* rtl/kst_pkg.sv */
// ----------------------------------------------------------------------------
// kst_pkg
// Shared widths, request codes, status codes and parameter defaults for the
// keyed shape table.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int REQ_W    = 3;
  localparam int STATUS_W = 3;
  localparam int KIND_W   = 2;

  localparam int DEF_MAX_ENTRIES = 64;
  localparam int DEF_COORD_WIDTH = 16;
  localparam int DEF_ID_WIDTH    = 16;

  localparam logic [REQ_W-1:0] REQ_ADD  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DEL  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_MOD  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLR  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LIST = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

endpackage

/* rtl/keyed_shape_table_core.sv */
// ----------------------------------------------------------------------------
// keyed_shape_table_core
// Ordered table of shape records with auto-assigned ids: add, delete,
// modify, clear and list, sequenced over one entry RAM port pair.
// ----------------------------------------------------------------------------
// Add, clear: result registered in the cycle after accept; unknown codes give none.
// Delete/modify: search streams one entry per cycle;
//   delete then shifts later entries down, one per cycle.
// List: each entry is read (S_LRD), latched (S_LDAT) and held in S_LOUT until taken.
// One transaction in flight; in_stall is high until its last result is taken.
// Synchronous active-low reset empties the table and restarts ids at 1.
// ----------------------------------------------------------------------------
module keyed_shape_table_core import kst_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int ID_WIDTH    = DEF_ID_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [REQ_W-1:0]              in_req_type,
  input  logic [ID_WIDTH-1:0]           in_target_id,
  input  logic [KIND_W-1:0]             in_shape_kind,
  input  logic signed [COORD_WIDTH-1:0] in_coord_a,
  input  logic signed [COORD_WIDTH-1:0] in_coord_b,
  input  logic signed [COORD_WIDTH-1:0] in_coord_c,
  input  logic signed [COORD_WIDTH-1:0] in_coord_d,
  input  logic signed [COORD_WIDTH-1:0] in_coord_e,
  input  logic signed [COORD_WIDTH-1:0] in_coord_f,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [STATUS_W-1:0]           out_status,
  output logic [ID_WIDTH-1:0]           out_entry_id,
  output logic [KIND_W-1:0]             out_kind,
  output logic signed [COORD_WIDTH-1:0] out_a,
  output logic signed [COORD_WIDTH-1:0] out_b,
  output logic signed [COORD_WIDTH-1:0] out_c,
  output logic signed [COORD_WIDTH-1:0] out_d,
  output logic signed [COORD_WIDTH-1:0] out_e,
  output logic signed [COORD_WIDTH-1:0] out_f,
  output logic                          out_last_item
);

  localparam int AW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int PAY_W   = KIND_W + 6 * COORD_WIDTH;
  localparam int ENTRY_W = ID_WIDTH + PAY_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_LRD   = 3'd3;
  localparam logic [2:0] S_LDAT  = 3'd4;
  localparam logic [2:0] S_LOUT  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ID_WIDTH-1:0] next_id_r, next_id_nxt;
  logic [CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic                pend_r, pend_nxt;

  logic [REQ_W-1:0]    req_r;
  logic [ID_WIDTH-1:0] target_r;
  logic [PAY_W-1:0]    pay_r;

  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     status_r, status_nxt;
  logic [ID_WIDTH-1:0]     entry_id_r, entry_id_nxt;
  logic [PAY_W-1:0]        out_pay_r, out_pay_nxt;
  logic                    last_r, last_nxt;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
  logic [ID_WIDTH-1:0] rd_id;
  logic [PAY_W-1:0]    in_pay;

  logic                in_fire, out_fire, issue;
  logic                emit;
  logic [STATUS_W-1:0] emit_status;
  logic [ID_WIDTH-1:0] emit_id;

  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign in_pay   = {in_shape_kind, in_coord_a, in_coord_b, in_coord_c,
                     in_coord_d, in_coord_e, in_coord_f};
  assign rd_id    = ram_rdata[ENTRY_W-1 -: ID_WIDTH];
  assign issue    = rd_idx_r < count_r;

  kst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    next_id_nxt   = next_id_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    entry_id_nxt  = entry_id_r;
    out_pay_nxt   = out_pay_r;
    last_nxt      = last_r;
    ram_we        = 1'b0;
    ram_waddr     = cmp_idx_r[AW-1:0];
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = rd_idx_r[AW-1:0];
    emit          = 1'b0;
    emit_status   = ST_OK;
    emit_id       = '0;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_req_type)
            REQ_ADD: begin
              emit = 1'b1;
              if (count_r >= CNT_W'(MAX_ENTRIES)) begin
                emit_status = ST_FULL;
              end else if (next_id_r == '0) begin
                emit_status = ST_EXHAUSTED;
              end else begin
                ram_we      = 1'b1;
                ram_waddr   = count_r[AW-1:0];
                ram_wdata   = {next_id_r, in_pay};
                count_nxt   = count_r + CNT_W'(1);
                next_id_nxt = next_id_r + ID_WIDTH'(1);
                emit_id     = next_id_r;
              end
            end
            REQ_DEL, REQ_MOD: begin
              if (count_r == '0) begin
                emit        = 1'b1;
                emit_status = ST_NOT_FOUND;
              end else begin
                state_nxt  = S_SRCH;
                rd_idx_nxt = '0;
                pend_nxt   = 1'b0;
              end
            end
            REQ_CLR: begin
              emit        = 1'b1;
              count_nxt   = '0;
              next_id_nxt = ID_WIDTH'(1);
            end
            REQ_LIST: begin
              if (count_r == '0) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                state_nxt  = S_LRD;
                rd_idx_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_SRCH: begin
        ram_re      = issue;
        pend_nxt    = issue;
        cmp_idx_nxt = rd_idx_r;
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (pend_r) begin
          if (rd_id == target_r) begin
            if (req_r == REQ_MOD) begin
              ram_we    = 1'b1;
              ram_wdata = {rd_id, pay_r};
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              state_nxt  = S_SHIFT;
              rd_idx_nxt = cmp_idx_r + CNT_W'(1);
              pend_nxt   = 1'b0;
            end
          end else if (cmp_idx_r == count_r - CNT_W'(1)) begin
            emit        = 1'b1;
            emit_status = ST_NOT_FOUND;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_SHIFT: begin
        ram_re      = issue;
        pend_nxt    = issue;
        cmp_idx_nxt = rd_idx_r - CNT_W'(1);
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (pend_r) begin
          ram_we = 1'b1;
        end
        if (!issue && !pend_r) begin
          count_nxt = count_r - CNT_W'(1);
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LRD: begin
        ram_re    = 1'b1;
        state_nxt = S_LDAT;
      end
      S_LDAT: begin
        out_valid_nxt = 1'b1;
        status_nxt    = ST_OK;
        entry_id_nxt  = rd_id;
        out_pay_nxt   = ram_rdata[PAY_W-1:0];
        last_nxt      = (rd_idx_r == count_r - CNT_W'(1));
        state_nxt     = S_LOUT;
      end
      S_LOUT: begin
        if (out_fire) begin
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + CNT_W'(1);
            state_nxt  = S_LRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      status_nxt    = emit_status;
      entry_id_nxt  = emit_id;
      out_pay_nxt   = '0;
      last_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      next_id_r   <= ID_WIDTH'(1);
      rd_idx_r    <= '0;
      cmp_idx_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      next_id_r   <= next_id_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r    <= in_req_type;
      target_r <= in_target_id;
      pay_r    <= in_pay;
    end
    status_r   <= status_nxt;
    entry_id_r <= entry_id_nxt;
    out_pay_r  <= out_pay_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_entry_id  = entry_id_r;
  assign out_kind      = out_pay_r[PAY_W-1 -: KIND_W];
  assign out_a         = out_pay_r[6*COORD_WIDTH-1 -: COORD_WIDTH];
  assign out_b         = out_pay_r[5*COORD_WIDTH-1 -: COORD_WIDTH];
  assign out_c         = out_pay_r[4*COORD_WIDTH-1 -: COORD_WIDTH];
  assign out_d         = out_pay_r[3*COORD_WIDTH-1 -: COORD_WIDTH];
  assign out_e         = out_pay_r[2*COORD_WIDTH-1 -: COORD_WIDTH];
  assign out_f         = out_pay_r[COORD_WIDTH-1:0];
  assign out_last_item = last_r;

endmodule

/* rtl/kst_ram.sv */
// ----------------------------------------------------------------------------
// kst_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
